// File: rtl/kpvf_pkg.sv
// Shared types, constants and helpers for the position/velocity Kalman filter.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none
package kpvf_pkg;

  localparam int FRAC        = 16;
  localparam int WORD        = 48;
  localparam int SAMPLE_BITS = 12;

  localparam logic signed [WORD-1:0] MAG48     = {1'b0, {(WORD-1){1'b1}}};
  localparam logic signed [WORD-1:0] ONE_FX    = 48'sd1 <<< FRAC;
  localparam logic signed [WORD-1:0] FULL_FX   = 48'sd4095 <<< FRAC;
  localparam logic        [15:0]     DT_RESET  = 16'd1311;
  localparam logic        [31:0]     QP_RESET  = 32'd3277;
  localparam logic        [31:0]     QV_RESET  = 32'd3277;
  localparam logic        [31:0]     R_RESET   = 32'd3276800;

  // Configuration register indexes
  localparam logic [3:0] CFG_TIME_STEP   = 4'd0;
  localparam logic [3:0] CFG_NOISE_POS   = 4'd1;
  localparam logic [3:0] CFG_NOISE_VEL   = 4'd2;
  localparam logic [3:0] CFG_NOISE_MEAS  = 4'd3;

  typedef logic signed [WORD-1:0] fx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRED_X,
    ST_PRED_DTVV,
    ST_PRED_PP,
    ST_INNOV,
    ST_GAIN_0,
    ST_GAIN_1,
    ST_UPD_X,
    ST_UPD_V,
    ST_UPD_PP,
    ST_UPD_PV,
    ST_UPD_VP,
    ST_UPD_VV,
    ST_CLAMP,
    ST_LEVEL,
    ST_PERCENT,
    ST_OUTPUT
  } seq_state_t;

  // Quotient and remainder from the shared divider
  typedef struct packed {
    logic [WORD-1:0] quot;
    logic [WORD-1:0] rem;
  } div_res_t;

  // Three-term sum saturated symmetrically to +-(2^47 - 1)
  function automatic fx_t add3(input fx_t a, input fx_t b, input fx_t c);
    logic signed [WORD+1:0] t;
    t = 50'(a) + 50'(b) + 50'(c);
    if (t > 50'(MAG48)) begin
      return MAG48;
    end else if (t < -50'(MAG48)) begin
      return -MAG48;
    end else begin
      return t[WORD-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/kpvf_mul.sv
// Shared fixed-point multiplier: sums three 48x16 partial products, one 16-bit slice of b each.
// Truncates the magnitude by FRAC bits and saturates. Uses kpvf_pkg.
`default_nettype none
module kpvf_mul (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire kpvf_pkg::fx_t a,
  input  wire kpvf_pkg::fx_t b,
  output logic               done,
  output kpvf_pkg::fx_t      result
);

  localparam int W = kpvf_pkg::WORD;

  logic          busy_r, busy_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic          neg_r, neg_nxt;
  logic [W-1:0]  ma_r, ma_nxt;
  logic [W-1:0]  mb_r, mb_nxt;
  logic [2*W-1:0] p_r, p_nxt;
  logic [63:0]   part;
  logic [W-1:0]  mag;

  assign part = ma_r * mb_r[15:0];

  // Accumulate one 16-bit slice of the multiplier per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
      neg_nxt  = a[W-1] ^ b[W-1];
      ma_nxt   = a[W-1] ? W'(-a) : W'(a);
      mb_nxt   = b[W-1] ? W'(-b) : W'(b);
      p_nxt    = '0;
    end else if (busy_r) begin
      p_nxt  = {part + 64'(p_r[2*W-1:W]), p_r[W-1:16]};
      mb_nxt = mb_r >> 16;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    p_r   <= p_nxt;
  end

  // Saturate the truncated magnitude and restore the sign
  assign mag    = (|p_r[2*W-1:kpvf_pkg::FRAC+W-1]) ? kpvf_pkg::MAG48
                : {1'b0, p_r[kpvf_pkg::FRAC+W-2:kpvf_pkg::FRAC]};
  assign result = neg_r ? -$signed(mag) : $signed(mag);
  assign done   = done_r;

endmodule
`default_nettype wire

// File: rtl/kpvf_div.sv
// Shared restoring divider: 64-bit dividend by 48-bit divisor, one bit a cycle.
// Quotient saturates to 2^47 - 1. Uses kpvf_pkg.
`default_nettype none
module kpvf_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [63:0]                   num,
  input  wire logic [kpvf_pkg::WORD-1:0]     den,
  output logic                               done,
  output kpvf_pkg::div_res_t                 res
);

  localparam int W = kpvf_pkg::WORD;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [63:0]   n_r, n_nxt;
  logic [63:0]   q_r, q_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem_r, n_r[63]};
  assign ge    = trial >= {1'b0, d_r};

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      n_nxt    = num;
      q_nxt    = '0;
      d_nxt    = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? W'(trial - {1'b0, d_r}) : W'(trial);
      q_nxt   = {q_r[62:0], ge};
      n_nxt   = n_r << 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign res.quot = (q_r > 64'(kpvf_pkg::MAG48)) ? kpvf_pkg::MAG48 : q_r[W-1:0];
  assign res.rem  = rem_r;

endmodule
`default_nettype wire

// File: rtl/kalman_position_velocity_filter.sv
// Position/velocity Kalman filter for a 12-bit slider sample.
//
// Input channel: in_valid / in_stall with in_sample. A transaction is taken
// only while the sequencer is idle; in_stall is high for the whole filter run.
// Result channel: out_valid / out_stall with position, levels and percents,
// one result transaction per input transaction, held in an output register.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data.
// Index 0 time step, 1 position noise, 2 velocity noise, 3 measurement
// noise; other indexes are ignored. Write only while the filter is idle.
//
// Each accepted sample runs nine multiplies on the shared multiplier, which
// works in 48x16 slices, and four divides on the shared bit-serial divider,
// with innovation, clamp and output-load states between them. When the
// innovation variance is not positive both gain divides are skipped. The
// next sample is taken the cycle after the result is placed in the output
// register, so a new sample is not accepted before the last one is through.
// Reset puts the state estimate at zero, the covariance at identity and
// the registers at their defaults. A stalled result stays in the output
// register; the sequencer waits in its final state until it can load it.
`default_nettype none
module kalman_position_velocity_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_position_12,
  output logic [7:0]       out_level_8,
  output logic [7:0]       out_level_8_inverted,
  output logic [6:0]       out_percent,
  output logic [6:0]       out_percent_inverted,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int W = kpvf_pkg::WORD;
  localparam int F = kpvf_pkg::FRAC;

  kpvf_pkg::seq_state_t state_r, state_nxt;

  logic [15:0] dt_r;
  logic [31:0] qp_r, qv_r, r_r;
  logic        op_wait_r, op_wait_nxt;
  logic [11:0] sample_r, sample_nxt;

  kpvf_pkg::fx_t x_r, x_nxt, v_r, v_nxt;
  kpvf_pkg::fx_t pp_r, pp_nxt, pv_r, pv_nxt, vp_r, vp_nxt, vv_r, vv_nxt;
  kpvf_pkg::fx_t xp_r, xp_nxt, inner_r, inner_nxt;
  kpvf_pkg::fx_t p00_r, p00_nxt, p01_r, p01_nxt, p10_r, p10_nxt, p11_r, p11_nxt;
  kpvf_pkg::fx_t s_r, s_nxt, y_r, y_nxt, k0_r, k0_nxt, k1_r, k1_nxt;
  kpvf_pkg::fx_t xc_r, xc_nxt;

  logic [11:0] pos_r, pos_nxt;
  logic [7:0]  lvl_r, lvl_nxt, lvli_r, lvli_nxt;
  logic [6:0]  pct_r, pct_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] o_pos_r, o_pos_nxt;
  logic [7:0]  o_lvl_r, o_lvl_nxt, o_lvli_r, o_lvli_nxt;
  logic [6:0]  o_pct_r, o_pct_nxt, o_pcti_r, o_pcti_nxt;

  kpvf_pkg::fx_t dt_fx, qp_fx, qv_fx, r_fx, meas_fx;
  kpvf_pkg::fx_t mul_a, mul_b, mul_res;
  logic          mul_start, mul_done;
  logic [63:0]   div_num;
  logic [W-1:0]  div_den;
  logic          div_start, div_done;
  kpvf_pkg::div_res_t div_res;
  kpvf_pkg::fx_t quot_fx;
  kpvf_pkg::fx_t p00_mag;
  logic          load_out;

  assign dt_fx   = $signed({32'd0, dt_r});
  assign qp_fx   = $signed({16'd0, qp_r});
  assign qv_fx   = $signed({16'd0, qv_r});
  assign r_fx    = $signed({16'd0, r_r});
  assign meas_fx = $signed({20'd0, sample_r, 16'd0});
  assign quot_fx = $signed(div_res.quot);
  assign p00_mag = p00_r[W-1] ? -p00_r : p00_r;

  assign in_stall  = (state_r != kpvf_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == kpvf_pkg::ST_OUTPUT) && (!out_valid_r || !out_stall);

  kpvf_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  kpvf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .res   (div_res)
  );

  // Next state: advance as each shared-unit operation completes
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kpvf_pkg::ST_IDLE:      if (in_valid) state_nxt = kpvf_pkg::ST_PRED_X;
      kpvf_pkg::ST_PRED_X:    if (mul_done) state_nxt = kpvf_pkg::ST_PRED_DTVV;
      kpvf_pkg::ST_PRED_DTVV: if (mul_done) state_nxt = kpvf_pkg::ST_PRED_PP;
      kpvf_pkg::ST_PRED_PP:   if (mul_done) state_nxt = kpvf_pkg::ST_INNOV;
      kpvf_pkg::ST_INNOV:     state_nxt = kpvf_pkg::ST_GAIN_0;
      kpvf_pkg::ST_GAIN_0: begin
        if (s_r <= 0) state_nxt = kpvf_pkg::ST_UPD_X;
        else if (div_done) state_nxt = kpvf_pkg::ST_GAIN_1;
      end
      kpvf_pkg::ST_GAIN_1:    if (div_done) state_nxt = kpvf_pkg::ST_UPD_X;
      kpvf_pkg::ST_UPD_X:     if (mul_done) state_nxt = kpvf_pkg::ST_UPD_V;
      kpvf_pkg::ST_UPD_V:     if (mul_done) state_nxt = kpvf_pkg::ST_UPD_PP;
      kpvf_pkg::ST_UPD_PP:    if (mul_done) state_nxt = kpvf_pkg::ST_UPD_PV;
      kpvf_pkg::ST_UPD_PV:    if (mul_done) state_nxt = kpvf_pkg::ST_UPD_VP;
      kpvf_pkg::ST_UPD_VP:    if (mul_done) state_nxt = kpvf_pkg::ST_UPD_VV;
      kpvf_pkg::ST_UPD_VV:    if (mul_done) state_nxt = kpvf_pkg::ST_CLAMP;
      kpvf_pkg::ST_CLAMP:     state_nxt = kpvf_pkg::ST_LEVEL;
      kpvf_pkg::ST_LEVEL:     if (div_done) state_nxt = kpvf_pkg::ST_PERCENT;
      kpvf_pkg::ST_PERCENT:   if (div_done) state_nxt = kpvf_pkg::ST_OUTPUT;
      kpvf_pkg::ST_OUTPUT:    if (load_out) state_nxt = kpvf_pkg::ST_IDLE;
      default:                state_nxt = kpvf_pkg::ST_IDLE;
    endcase
  end

  // Datapath: steer operands to the shared units and capture their results
  always_comb begin
    sample_nxt = sample_r;
    x_nxt = x_r;   v_nxt = v_r;
    pp_nxt = pp_r; pv_nxt = pv_r; vp_nxt = vp_r; vv_nxt = vv_r;
    xp_nxt = xp_r; inner_nxt = inner_r;
    p00_nxt = p00_r; p01_nxt = p01_r; p10_nxt = p10_r; p11_nxt = p11_r;
    s_nxt = s_r; y_nxt = y_r; k0_nxt = k0_r; k1_nxt = k1_r;
    xc_nxt = xc_r;
    pos_nxt = pos_r; lvl_nxt = lvl_r; lvli_nxt = lvli_r; pct_nxt = pct_r;
    mul_a = '0;
    mul_b = '0;
    mul_start = 1'b0;
    div_num = '0;
    div_den = '0;
    div_start = 1'b0;
    case (state_r)
      kpvf_pkg::ST_IDLE: begin
        if (in_valid) sample_nxt = in_sample;
      end
      kpvf_pkg::ST_PRED_X: begin
        mul_a = v_r; mul_b = dt_fx; mul_start = !op_wait_r;
        if (mul_done) xp_nxt = kpvf_pkg::add3(x_r, mul_res, '0);
      end
      kpvf_pkg::ST_PRED_DTVV: begin
        mul_a = dt_fx; mul_b = vv_r; mul_start = !op_wait_r;
        if (mul_done) begin
          inner_nxt = kpvf_pkg::add3(pv_r, vp_r, mul_res);
          p01_nxt   = kpvf_pkg::add3(pv_r, mul_res, '0);
          p10_nxt   = kpvf_pkg::add3(vp_r, mul_res, '0);
          p11_nxt   = kpvf_pkg::add3(vv_r, qv_fx, '0);
        end
      end
      kpvf_pkg::ST_PRED_PP: begin
        mul_a = dt_fx; mul_b = inner_r; mul_start = !op_wait_r;
        if (mul_done) p00_nxt = kpvf_pkg::add3(pp_r, mul_res, qp_fx);
      end
      kpvf_pkg::ST_INNOV: begin
        s_nxt = kpvf_pkg::add3(p00_r, r_fx, '0);
        y_nxt = kpvf_pkg::add3(meas_fx, -xp_r, '0);
      end
      kpvf_pkg::ST_GAIN_0: begin
        div_num = {1'b0, p00_mag[W-2:0], 16'd0};
        div_den = s_r;
        if (s_r <= 0) begin
          k0_nxt = '0;
          k1_nxt = '0;
        end else begin
          div_start = !op_wait_r;
          if (div_done) k0_nxt = p00_r[W-1] ? -quot_fx : quot_fx;
        end
      end
      kpvf_pkg::ST_GAIN_1: begin
        div_num = p10_r[W-1] ? {1'b0, 47'(-p10_r), 16'd0} : {1'b0, p10_r[W-2:0], 16'd0};
        div_den = s_r;
        div_start = !op_wait_r;
        if (div_done) k1_nxt = p10_r[W-1] ? -quot_fx : quot_fx;
      end
      kpvf_pkg::ST_UPD_X: begin
        mul_a = k0_r; mul_b = y_r; mul_start = !op_wait_r;
        if (mul_done) x_nxt = kpvf_pkg::add3(xp_r, mul_res, '0);
      end
      kpvf_pkg::ST_UPD_V: begin
        mul_a = k1_r; mul_b = y_r; mul_start = !op_wait_r;
        if (mul_done) v_nxt = kpvf_pkg::add3(v_r, mul_res, '0);
      end
      kpvf_pkg::ST_UPD_PP: begin
        mul_a = k0_r; mul_b = p00_r; mul_start = !op_wait_r;
        if (mul_done) pp_nxt = kpvf_pkg::add3(p00_r, -mul_res, '0);
      end
      kpvf_pkg::ST_UPD_PV: begin
        mul_a = k0_r; mul_b = p01_r; mul_start = !op_wait_r;
        if (mul_done) pv_nxt = kpvf_pkg::add3(p01_r, -mul_res, '0);
      end
      kpvf_pkg::ST_UPD_VP: begin
        mul_a = k1_r; mul_b = p00_r; mul_start = !op_wait_r;
        if (mul_done) vp_nxt = kpvf_pkg::add3(p10_r, -mul_res, '0);
      end
      kpvf_pkg::ST_UPD_VV: begin
        mul_a = k1_r; mul_b = p01_r; mul_start = !op_wait_r;
        if (mul_done) vv_nxt = kpvf_pkg::add3(p11_r, -mul_res, '0);
      end
      kpvf_pkg::ST_CLAMP: begin
        if (x_r < 0) xc_nxt = '0;
        else if (x_r > kpvf_pkg::FULL_FX) xc_nxt = kpvf_pkg::FULL_FX;
        else xc_nxt = x_r;
      end
      kpvf_pkg::ST_LEVEL: begin
        pos_nxt = xc_r[F+11:F];
        div_num = {16'd0, xc_r} * 64'd255;
        div_den = kpvf_pkg::FULL_FX;
        div_start = !op_wait_r;
        if (div_done) begin
          lvl_nxt  = div_res.quot[7:0];
          lvli_nxt = 8'd255 - div_res.quot[7:0] - {7'd0, (div_res.rem != '0)};
        end
      end
      kpvf_pkg::ST_PERCENT: begin
        div_num = {16'd0, xc_r} * 64'd100;
        div_den = kpvf_pkg::FULL_FX;
        div_start = !op_wait_r;
        if (div_done) pct_nxt = div_res.quot[6:0];
      end
      default: begin
      end
    endcase
  end

  // Track an outstanding shared-unit operation
  always_comb begin
    op_wait_nxt = op_wait_r;
    if (mul_start || div_start) op_wait_nxt = 1'b1;
    if (mul_done || div_done) op_wait_nxt = 1'b0;
  end

  // Output register: load when empty or when the held transaction leaves
  always_comb begin
    out_valid_nxt = out_valid_r;
    o_pos_nxt  = o_pos_r;
    o_lvl_nxt  = o_lvl_r;
    o_lvli_nxt = o_lvli_r;
    o_pct_nxt  = o_pct_r;
    o_pcti_nxt = o_pcti_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      o_pos_nxt  = pos_r;
      o_lvl_nxt  = lvl_r;
      o_lvli_nxt = lvli_r;
      o_pct_nxt  = pct_r;
      o_pcti_nxt = 7'd100 - pct_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kpvf_pkg::ST_IDLE;
      op_wait_r   <= 1'b0;
      out_valid_r <= 1'b0;
      dt_r <= kpvf_pkg::DT_RESET;
      qp_r <= kpvf_pkg::QP_RESET;
      qv_r <= kpvf_pkg::QV_RESET;
      r_r  <= kpvf_pkg::R_RESET;
      x_r  <= '0;
      v_r  <= '0;
      pp_r <= kpvf_pkg::ONE_FX;
      pv_r <= '0;
      vp_r <= '0;
      vv_r <= kpvf_pkg::ONE_FX;
    end else begin
      state_r     <= state_nxt;
      op_wait_r   <= op_wait_nxt;
      out_valid_r <= out_valid_nxt;
      x_r  <= x_nxt;
      v_r  <= v_nxt;
      pp_r <= pp_nxt;
      pv_r <= pv_nxt;
      vp_r <= vp_nxt;
      vv_r <= vv_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          kpvf_pkg::CFG_TIME_STEP:  dt_r <= cfg_data[15:0];
          kpvf_pkg::CFG_NOISE_POS:  qp_r <= cfg_data;
          kpvf_pkg::CFG_NOISE_VEL:  qv_r <= cfg_data;
          kpvf_pkg::CFG_NOISE_MEAS: r_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    sample_r <= sample_nxt;
    xp_r <= xp_nxt;   inner_r <= inner_nxt;
    p00_r <= p00_nxt; p01_r <= p01_nxt; p10_r <= p10_nxt; p11_r <= p11_nxt;
    s_r <= s_nxt;     y_r <= y_nxt;     k0_r <= k0_nxt;   k1_r <= k1_nxt;
    xc_r <= xc_nxt;
    pos_r <= pos_nxt; lvl_r <= lvl_nxt; lvli_r <= lvli_nxt; pct_r <= pct_nxt;
    o_pos_r <= o_pos_nxt; o_lvl_r <= o_lvl_nxt; o_lvli_r <= o_lvli_nxt;
    o_pct_r <= o_pct_nxt; o_pcti_r <= o_pcti_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_position_12      = o_pos_r;
  assign out_level_8          = o_lvl_r;
  assign out_level_8_inverted = o_lvli_r;
  assign out_percent          = o_pct_r;
  assign out_percent_inverted = o_pcti_r;

  // Never issue two operations back to back on the shared units
  a_mul_single: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |=> !mul_start)
    else $error("multiplier restarted while busy");

  a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_start)
    else $error("divider restarted while busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kpvf_pkg::ST_IDLE) |-> !op_wait_r)
    else $error("operation pending while idle");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == kpvf_pkg::ST_PRED_X))
    else $error("accepted transaction did not start the filter");

endmodule
`default_nettype wire
